[hdl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, character codes and helper functions for the string body
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'd0,
        MODE_ESCAPE  = 4'd1,
        MODE_HEX_A   = 4'd2,
        MODE_HIGH    = 4'd3,
        MODE_HIGH_BS = 4'd4,
        MODE_HEX_B   = 4'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_CLOSE = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } result_t;

    // Up to four UTF-8 bytes and their count.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CP_W        = 21;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    // 0x10000 - 0xDC00, the fixed part of the surrogate pair sum.
    localparam logic [CP_W-1:0] PAIR_BIAS = 21'h02400;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
        utf8_t u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

`default_nettype wire

[hdl/jsu_in_if.sv]
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte of a JSON string body.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_ended;

    modport source (output valid, output in_byte, output source_ended, input ready);
    modport sink   (input valid, input in_byte, input source_ended, output ready);
endinterface

`default_nettype wire

[hdl/jsu_out_if.sv]
// ----------------------------------------------------------------------------
// Decoded byte channel
// Valid/ready channel carrying one decoded UTF-8 byte or an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

[hdl/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes a JSON string body byte by byte, resolving escapes and \u units
// (with surrogate pairs) into UTF-8, and marks the close or an error.
// ----------------------------------------------------------------------------
//  Port     Dir  Payload                            Transfer
//  in_chan  in   in_byte[7:0], source_ended         valid & ready
//  out_chan out  out_byte[7:0], status[1:0], last   valid & ready
//
//  A source byte is decoded in the cycle it is taken and its up to four
//  results land in a four-entry result buffer, sent one per cycle while
//  the output is ready. A byte that gives no result leaves the input ready;
//  one that gives results holds the input until all but the last are sent.
//  The input is taken again in the cycle the last buffered result is sent.
//  Reset returns the decoder to plain character mode with an empty buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
    input  wire        clk,
    input  wire        rst_n,
    jsu_in_if.sink     in_chan,
    jsu_out_if.source  out_chan
);

    jsu_pkg::mode_t   mode_reg, mode_next;
    logic [15:0]      acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [15:0]      pend_reg, pend_next;

    jsu_pkg::result_t buf_reg [jsu_pkg::MAX_RESULTS];
    jsu_pkg::result_t buf_next [jsu_pkg::MAX_RESULTS];
    logic [2:0]       buf_cnt_reg, buf_cnt_next;
    logic [1:0]       rd_reg, rd_next;
    logic [2:0]       res_n;

    logic             in_fire;
    logic             out_fire;
    logic             out_last;

    assign out_last      = ({1'b0, rd_reg} == (buf_cnt_reg - 3'd1));
    assign out_chan.valid = (buf_cnt_reg != 3'd0);
    assign out_fire      = out_chan.valid && out_chan.ready;
    assign in_chan.ready = (buf_cnt_reg == 3'd0) || (out_chan.ready && out_last);
    assign in_fire       = in_chan.valid && in_chan.ready;

    assign out_chan.out_byte    = buf_reg[rd_reg].data;
    assign out_chan.status      = buf_reg[rd_reg].status;
    assign out_chan.last_of_run = out_last;

    // Decode of one source byte against the current mode.
    always_comb
    begin
        logic [7:0]       c;
        jsu_pkg::hex_t    hx;
        logic [15:0]      acc_new;
        logic [2:0]       cnt_new;
        logic [jsu_pkg::CP_W-1:0] pair_cp;
        jsu_pkg::utf8_t   pre;
        logic [2:0]       pre_n;
        jsu_pkg::utf8_t   enc;
        jsu_pkg::result_t main_r [jsu_pkg::MAX_RESULTS];
        logic [2:0]       main_n;
        logic             do_norm;
        logic             do_esc;
        logic             failed;
        logic             clear;
        logic [7:0]       esc_val;
        logic [2:0]       j;

        c        = in_chan.in_byte;
        hx       = jsu_pkg::hex_decode(c);
        acc_new  = {acc_reg[11:0], hx.val};
        cnt_new  = cnt_reg + 3'd1;
        pair_cp  = {1'b0, pend_reg[9:0], 10'd0} + jsu_pkg::PAIR_BIAS
                   + {5'd0, acc_new};
        pre      = jsu_pkg::utf8_encode({5'd0, pend_reg});
        pre_n    = 3'd0;
        enc      = jsu_pkg::utf8_encode({5'd0, acc_new});
        main_n   = 3'd0;
        do_norm  = 1'b0;
        do_esc   = 1'b0;
        failed   = 1'b0;
        clear    = 1'b0;
        esc_val  = 8'd0;
        j        = 3'd0;
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
        begin
            main_r[i]  = '{8'd0, jsu_pkg::ST_DATA};
            buf_next[i] = '{8'd0, jsu_pkg::ST_DATA};
        end

        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;

        case (mode_reg)
            jsu_pkg::MODE_ESCAPE:
            begin
                do_esc = 1'b1;
            end
            jsu_pkg::MODE_HEX_A:
            begin
                if (!hx.ok)
                begin
                    failed = 1'b1;
                end
                else if (cnt_new >= 3'd4)
                begin
                    acc_next = 16'd0;
                    cnt_next = 3'd0;
                    if (acc_new >= jsu_pkg::HIGH_FIRST && acc_new <= jsu_pkg::HIGH_LAST)
                    begin
                        pend_next = acc_new;
                        mode_next = jsu_pkg::MODE_HIGH;
                    end
                    else
                    begin
                        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
                        begin
                            main_r[i] = '{enc.bytes[i], jsu_pkg::ST_DATA};
                        end
                        main_n    = enc.len;
                        mode_next = jsu_pkg::MODE_NORMAL;
                    end
                end
                else
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                end
            end
            jsu_pkg::MODE_HIGH:
            begin
                if (c == jsu_pkg::CH_BACKSLASH)
                begin
                    mode_next = jsu_pkg::MODE_HIGH_BS;
                end
                else
                begin
                    pre_n     = pre.len;
                    pend_next = 16'd0;
                    do_norm   = 1'b1;
                end
            end
            jsu_pkg::MODE_HIGH_BS:
            begin
                if (c == jsu_pkg::CH_U)
                begin
                    mode_next = jsu_pkg::MODE_HEX_B;
                    acc_next  = 16'd0;
                    cnt_next  = 3'd0;
                end
                else
                begin
                    pre_n     = pre.len;
                    pend_next = 16'd0;
                    do_esc    = 1'b1;
                end
            end
            jsu_pkg::MODE_HEX_B:
            begin
                if (!hx.ok)
                begin
                    failed = 1'b1;
                end
                else if (cnt_new >= 3'd4)
                begin
                    enc = jsu_pkg::utf8_encode(pair_cp);
                    for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
                    begin
                        main_r[i] = '{enc.bytes[i], jsu_pkg::ST_DATA};
                    end
                    main_n = enc.len;
                    clear  = 1'b1;
                end
                else
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_new;
                end
            end
            default:
            begin
                do_norm = 1'b1;
            end
        endcase

        if (do_norm)
        begin
            mode_next = jsu_pkg::MODE_NORMAL;
            if (c == jsu_pkg::CH_QUOTE)
            begin
                main_r[0] = '{8'd0, jsu_pkg::ST_CLOSE};
                main_n    = 3'd1;
                clear     = 1'b1;
            end
            else if (c == jsu_pkg::CH_BACKSLASH)
            begin
                mode_next = jsu_pkg::MODE_ESCAPE;
            end
            else
            begin
                main_r[0] = '{c, jsu_pkg::ST_DATA};
                main_n    = 3'd1;
            end
        end

        if (do_esc)
        begin
            case (c)
                jsu_pkg::CH_QUOTE:     esc_val = jsu_pkg::CH_QUOTE;
                jsu_pkg::CH_BACKSLASH: esc_val = jsu_pkg::CH_BACKSLASH;
                jsu_pkg::CH_SLASH:     esc_val = jsu_pkg::CH_SLASH;
                jsu_pkg::CH_B:         esc_val = jsu_pkg::CTL_BS;
                jsu_pkg::CH_F:         esc_val = jsu_pkg::CTL_FF;
                jsu_pkg::CH_N:         esc_val = jsu_pkg::CTL_LF;
                jsu_pkg::CH_R:         esc_val = jsu_pkg::CTL_CR;
                jsu_pkg::CH_T:         esc_val = jsu_pkg::CTL_HT;
                default:               esc_val = 8'd0;
            endcase
            if (c == jsu_pkg::CH_U)
            begin
                mode_next = jsu_pkg::MODE_HEX_A;
                acc_next  = 16'd0;
                cnt_next  = 3'd0;
            end
            else if (esc_val == 8'd0)
            begin
                failed = 1'b1;
            end
            else
            begin
                main_r[0] = '{esc_val, jsu_pkg::ST_DATA};
                main_n    = 3'd1;
                mode_next = jsu_pkg::MODE_NORMAL;
            end
        end

        // A waiting surrogate comes first, then the bytes of this step.
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
        begin
            if (3'(i) < pre_n)
            begin
                buf_next[i] = '{pre.bytes[i], jsu_pkg::ST_DATA};
            end
            else
            begin
                j = 3'(i) - pre_n;
                if (j < main_n)
                begin
                    buf_next[i] = main_r[j[1:0]];
                end
            end
        end
        res_n = pre_n + main_n;

        // An ended source or a failed step voids everything else.
        if (in_chan.source_ended || failed)
        begin
            buf_next[0] = '{8'd0, jsu_pkg::ST_ERROR};
            res_n       = 3'd1;
            clear       = 1'b1;
        end

        if (clear)
        begin
            mode_next = jsu_pkg::MODE_NORMAL;
            acc_next  = 16'd0;
            cnt_next  = 3'd0;
            pend_next = 16'd0;
        end
    end

    // Result buffer pointers.
    always_comb
    begin
        buf_cnt_next = buf_cnt_reg;
        rd_next      = rd_reg;
        if (out_fire)
        begin
            if (out_last)
            begin
                buf_cnt_next = 3'd0;
                rd_next      = 2'd0;
            end
            else
            begin
                rd_next = rd_reg + 2'd1;
            end
        end
        if (in_fire && res_n != 3'd0)
        begin
            buf_cnt_next = res_n;
            rd_next      = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= jsu_pkg::MODE_NORMAL;
            acc_reg     <= 16'd0;
            cnt_reg     <= 3'd0;
            pend_reg    <= 16'd0;
            buf_cnt_reg <= 3'd0;
            rd_reg      <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                pend_reg <= pend_next;
            end
            buf_cnt_reg <= buf_cnt_next;
            rd_reg      <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_n != 3'd0)
        begin
            for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

endmodule

`default_nettype wire

[sim/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the JSON string unescape to UTF-8 decoder
// Feeds string bodies byte by byte: plain text, every escape, \u units of all
// UTF-8 lengths, surrogate pairs, lone surrogates and malformed or cut-off
// strings. Each accepted byte is decoded by a behavioural model in the bench
// and every transfer on the output channel is checked against the oldest
// predicted byte. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_json_string_unescape_utf8;

    localparam int RANDOM_ITEMS  = 196;
    localparam int STALL_LIMIT   = 1000;
    localparam int LONG_HOLD     = 150;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [31:0] PAIR_BASE  = 32'h0001_0000;
    localparam logic [31:0] HIGH_BASE  = 32'h0000_D800;
    localparam logic [31:0] LOW_BASE   = 32'h0000_DC00;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // The eight escape letters that stand for a single byte.
    localparam logic [63:0] SIMPLE_ESC = {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
                                          jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                          jsu_pkg::CH_F, jsu_pkg::CH_N,
                                          jsu_pkg::CH_R, jsu_pkg::CH_T};

    typedef struct packed {
        logic [7:0] ch;
        logic       ended;
        logic       settle;     // hold back until every predicted byte is out
    } src_item_t;

    typedef struct packed {
        logic [7:0]       data;
        jsu_pkg::status_t status;
        logic             last;
    } utf8_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    jsu_in_if  src_chan ();
    jsu_out_if dec_chan ();

    json_string_unescape_utf8 i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (src_chan),
        .out_chan (dec_chan)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    src_item_t    source_todo[$];
    utf8_result_t decoded_due[$];
    logic         settle_next = 1'b0;
    logic         src_taken   = 1'b0;
    int           in_count    = 0;
    int           total_items = 0;
    int           fail_count  = 0;
    int           src_gap     = 0;
    int           sink_gap    = 0;
    int           long_hold   = 0;
    logic         hold_done   = 1'b0;

    // Decoder state as the bench sees it.
    jsu_pkg::mode_t dec_mode    = jsu_pkg::MODE_NORMAL;
    logic [15:0]    unit_acc    = '0;
    logic [2:0]     unit_digits = '0;
    logic [15:0]    high_half   = '0;
    utf8_result_t   step_res [jsu_pkg::MAX_RESULTS];
    int             step_len;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void emit(input logic [31:0] v, input jsu_pkg::status_t st);
        if (step_len < jsu_pkg::MAX_RESULTS)
        begin
            step_res[step_len].data   = v[7:0];
            step_res[step_len].status = st;
            step_res[step_len].last   = 1'b0;
            step_len++;
        end
    endfunction

    // Lead bytes keep only their low eight bits, so out-of-range code points
    // from an unchecked pair still give four bytes.
    function automatic void emit_code_point(input logic [31:0] cp);
        if (cp <= 32'h7F)
        begin
            emit(cp, jsu_pkg::ST_DATA);
        end
        else if (cp <= 32'h7FF)
        begin
            emit(32'hC0 | (cp >> 6), jsu_pkg::ST_DATA);
            emit(32'h80 | (cp & 32'h3F), jsu_pkg::ST_DATA);
        end
        else if (cp <= 32'hFFFF)
        begin
            emit(32'hE0 | (cp >> 12), jsu_pkg::ST_DATA);
            emit(32'h80 | ((cp >> 6) & 32'h3F), jsu_pkg::ST_DATA);
            emit(32'h80 | (cp & 32'h3F), jsu_pkg::ST_DATA);
        end
        else
        begin
            emit(32'hF0 | (cp >> 18), jsu_pkg::ST_DATA);
            emit(32'h80 | ((cp >> 12) & 32'h3F), jsu_pkg::ST_DATA);
            emit(32'h80 | ((cp >> 6) & 32'h3F), jsu_pkg::ST_DATA);
            emit(32'h80 | (cp & 32'h3F), jsu_pkg::ST_DATA);
        end
    endfunction

    function automatic void reset_decoder();
        dec_mode    = jsu_pkg::MODE_NORMAL;
        unit_acc    = '0;
        unit_digits = '0;
        high_half   = '0;
    endfunction

    // An error voids whatever the same byte would otherwise have produced.
    function automatic void abandon_string();
        step_len = 0;
        emit(32'h0, jsu_pkg::ST_ERROR);
        reset_decoder();
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == jsu_pkg::CH_QUOTE)
        begin
            emit(32'h0, jsu_pkg::ST_CLOSE);
            reset_decoder();
        end
        else if (c == jsu_pkg::CH_BACKSLASH)
        begin
            dec_mode = jsu_pkg::MODE_ESCAPE;
        end
        else
        begin
            emit({24'h0, c}, jsu_pkg::ST_DATA);
        end
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        logic [7:0] v;
        logic       single;
        single = 1'b1;
        v      = 8'h00;
        case (c)
            jsu_pkg::CH_QUOTE:     v = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BACKSLASH: v = jsu_pkg::CH_BACKSLASH;
            jsu_pkg::CH_SLASH:     v = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:         v = jsu_pkg::CTL_BS;
            jsu_pkg::CH_F:         v = jsu_pkg::CTL_FF;
            jsu_pkg::CH_N:         v = jsu_pkg::CTL_LF;
            jsu_pkg::CH_R:         v = jsu_pkg::CTL_CR;
            jsu_pkg::CH_T:         v = jsu_pkg::CTL_HT;
            jsu_pkg::CH_U:
            begin
                dec_mode    = jsu_pkg::MODE_HEX_A;
                unit_acc    = '0;
                unit_digits = '0;
                single      = 1'b0;
            end
            default:
            begin
                abandon_string();
                single = 1'b0;
            end
        endcase
        if (single)
        begin
            emit({24'h0, v}, jsu_pkg::ST_DATA);
            dec_mode = jsu_pkg::MODE_NORMAL;
        end
    endfunction

    // Returns 1 once the fourth digit of a unit is in.
    function automatic logic hex_digit(input logic [7:0] c);
        int n;
        n = hex_nibble(c);
        if (n < 0)
        begin
            abandon_string();
            return 1'b0;
        end
        unit_acc    = {unit_acc[11:0], n[3:0]};
        unit_digits = unit_digits + 3'd1;
        return unit_digits >= 3'd4;
    endfunction

    function automatic void decode_source_byte(input logic [7:0] c, input logic ended);
        logic [15:0] code_unit;
        logic [31:0] cp;
        step_len = 0;
        if (ended)
        begin
            abandon_string();
        end
        else
        begin
            case (dec_mode)
                jsu_pkg::MODE_ESCAPE:
                begin
                    escape_char(c);
                end
                jsu_pkg::MODE_HEX_A:
                begin
                    if (hex_digit(c))
                    begin
                        code_unit   = unit_acc;
                        unit_acc    = '0;
                        unit_digits = '0;
                        if (code_unit >= jsu_pkg::HIGH_FIRST
                            && code_unit <= jsu_pkg::HIGH_LAST)
                        begin
                            high_half = code_unit;
                            dec_mode  = jsu_pkg::MODE_HIGH;
                        end
                        else
                        begin
                            emit_code_point({16'h0, code_unit});
                            dec_mode = jsu_pkg::MODE_NORMAL;
                        end
                    end
                end
                jsu_pkg::MODE_HIGH:
                begin
                    if (c == jsu_pkg::CH_BACKSLASH)
                    begin
                        dec_mode = jsu_pkg::MODE_HIGH_BS;
                    end
                    else
                    begin
                        emit_code_point({16'h0, high_half});
                        high_half = '0;
                        dec_mode  = jsu_pkg::MODE_NORMAL;
                        plain_char(c);
                    end
                end
                jsu_pkg::MODE_HIGH_BS:
                begin
                    if (c == jsu_pkg::CH_U)
                    begin
                        dec_mode    = jsu_pkg::MODE_HEX_B;
                        unit_acc    = '0;
                        unit_digits = '0;
                    end
                    else
                    begin
                        emit_code_point({16'h0, high_half});
                        high_half = '0;
                        dec_mode  = jsu_pkg::MODE_ESCAPE;
                        escape_char(c);
                    end
                end
                jsu_pkg::MODE_HEX_B:
                begin
                    if (hex_digit(c))
                    begin
                        // No range check on the second unit: the sum wraps at 32 bits.
                        cp = PAIR_BASE + (({16'h0, high_half} - HIGH_BASE) << 10)
                             + ({16'h0, unit_acc} - LOW_BASE);
                        emit_code_point(cp);
                        reset_decoder();
                    end
                end
                default:
                begin
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    plain_char(c);
                end
            endcase
        end
        for (int i = 0; i < step_len; i++)
        begin
            step_res[i].last = (i == step_len - 1);
            decoded_due.insert(decoded_due.size(), step_res[i]);
        end
    endfunction

    function automatic logic idling_allowed();
        return (source_todo.size() >= 40) && ((in_count % 96) < 72);
    endfunction

    task automatic queue_char(input logic [7:0] c);
        src_item_t it;
        it.ch       = c;
        it.ended    = 1'b0;
        it.settle   = settle_next;
        settle_next = 1'b0;
        source_todo.insert(source_todo.size(), it);
    endtask

    task automatic queue_end();
        src_item_t it;
        it.ch       = 8'($urandom_range(0, 255));
        it.ended    = 1'b1;
        it.settle   = settle_next;
        settle_next = 1'b0;
        source_todo.insert(source_todo.size(), it);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endtask

    // Four hex digits, each letter in a random case.
    task automatic queue_unit(input logic [15:0] u);
        logic [3:0] n;
        queue_char(jsu_pkg::CH_BACKSLASH);
        queue_char(jsu_pkg::CH_U);
        for (int k = 3; k >= 0; k--)
        begin
            n = u[k*4 +: 4];
            if (n < 4'd10)
                queue_char(8'h30 + n);
            else if ($urandom_range(0, 1) == 0)
                queue_char(8'h61 + n - 8'd10);
            else
                queue_char(8'h41 + n - 8'd10);
        end
    endtask

    // Source side: a byte is offered at a falling edge unless a gap or settle holds it.
    always @(negedge clk)
    begin : drive_source
        logic      offer;
        src_item_t cur;
        offer = src_chan.valid;
        if (!rst_n)
        begin
            offer = 1'b0;
        end
        else
        begin
            if (src_taken)
            begin
                src_taken = 1'b0;
                offer     = 1'b0;
                if (long_hold == 0 && idling_allowed() && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 16);
            end
            if (!offer)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (source_todo.size() > 0
                         && !(source_todo[0].settle && decoded_due.size() > 0))
                begin
                    cur = source_todo.pop_front();
                    src_chan.in_byte      <= cur.ch;
                    src_chan.source_ended <= cur.ended;
                    offer = 1'b1;
                end
            end
        end
        src_chan.valid <= offer;
    end

    // Sink side: random back-pressure plus one long hold-off so that the
    // result buffer fills and the input stalls.
    always @(negedge clk)
    begin : drive_sink
        if (!rst_n)
        begin
            dec_chan.ready <= 1'b0;
        end
        else
        begin
            if (!hold_done && in_count >= 40)
            begin
                hold_done = 1'b1;
                long_hold = LONG_HOLD;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                dec_chan.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                dec_chan.ready <= 1'b0;
            end
            else
            begin
                dec_chan.ready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 16);
            end
        end
    end

    // Input transfers are decoded before output transfers of the same edge
    // are checked.
    always @(posedge clk)
    begin : observe
        utf8_result_t want;
        if (rst_n)
        begin
            if (src_chan.valid && src_chan.ready)
            begin
                decode_source_byte(src_chan.in_byte, src_chan.source_ended);
                in_count++;
                src_taken = 1'b1;
            end
            if (dec_chan.valid && dec_chan.ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: byte %02h status %0d last %0b",
                             $time, dec_chan.out_byte, dec_chan.status,
                             dec_chan.last_of_run);
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (dec_chan.out_byte !== want.data || dec_chan.status !== want.status
                        || dec_chan.last_of_run !== want.last)
                    begin
                        fail_count++;
                        $display({"%0t: mismatch: expected byte %02h status %0d last %0b,",
                                  " got byte %02h status %0d last %0b"},
                                 $time, want.data, want.status, want.last,
                                 dec_chan.out_byte, dec_chan.status, dec_chan.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (rst_n)
        begin
            if ((src_chan.valid && src_chan.ready) || (dec_chan.valid && dec_chan.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
        else
        begin
            quiet = 0;
        end
    end

    initial
    begin : run
        int          n_directed;
        int          pick;
        logic [7:0]  c;
        logic [15:0] code_unit;
        logic [15:0] lo;
        logic        mid_settled;

        src_chan.valid        = 1'b0;
        src_chan.in_byte      = 8'h00;
        src_chan.source_ended = 1'b0;
        dec_chan.ready        = 1'b0;
        mid_settled           = 1'b0;

        // Directed: byte extremes and a close, an escape, a pair whose second
        // unit is out of range, a bad escape, a bad hex digit, source end.
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(jsu_pkg::CH_QUOTE);
        queue_char(jsu_pkg::CH_BACKSLASH);
        queue_char(jsu_pkg::CH_SLASH);
        queue_text("\\uDbFf\\u0000");
        queue_text("\\g");
        queue_text("\\u1G");
        queue_end();
        n_directed = source_todo.size();

        // Mostly well-formed text with a little noise; the first random byte
        // and one in the middle wait for the output to drain.
        settle_next = 1'b1;
        while (source_todo.size() < n_directed + RANDOM_ITEMS)
        begin
            if (!mid_settled && source_todo.size() >= n_directed + RANDOM_ITEMS / 2)
            begin
                settle_next = 1'b1;
                mid_settled = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 33)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
                queue_char(c);
            end
            else if (pick < 45)
            begin
                queue_char(jsu_pkg::CH_BACKSLASH);
                queue_char(SIMPLE_ESC[8 * $urandom_range(0, 7) +: 8]);
            end
            else if (pick < 58)
            begin
                case ($urandom_range(0, 4))
                    0:       code_unit = 16'($urandom_range(0, 'h7F));
                    1:       code_unit = 16'($urandom_range('h80, 'h7FF));
                    2:       code_unit = 16'($urandom_range('h800, 'hFFFF));
                    3:       code_unit = 16'($urandom_range(LOW_FIRST, LOW_LAST));
                    default: code_unit = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                endcase
                queue_unit(code_unit);
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 5))
                    0:       code_unit = jsu_pkg::HIGH_FIRST;
                    1:       code_unit = jsu_pkg::HIGH_LAST;
                    default: code_unit = 16'($urandom_range(jsu_pkg::HIGH_FIRST,
                                                            jsu_pkg::HIGH_LAST));
                endcase
                case ($urandom_range(0, 7))
                    0:       lo = LOW_FIRST;
                    1:       lo = LOW_LAST;
                    2:       lo = 16'($urandom_range(0, 'hFFFF));
                    default: lo = 16'($urandom_range(LOW_FIRST, LOW_LAST));
                endcase
                queue_unit(code_unit);
                queue_unit(lo);
            end
            else if (pick < 76)
            begin
                // A high half left alone; whatever follows decides its fate.
                queue_unit(16'($urandom_range(jsu_pkg::HIGH_FIRST, jsu_pkg::HIGH_LAST)));
            end
            else if (pick < 88)
            begin
                queue_char(jsu_pkg::CH_QUOTE);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        queue_char(jsu_pkg::CH_BACKSLASH);
                        queue_char(8'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        queue_char(jsu_pkg::CH_BACKSLASH);
                        queue_char(jsu_pkg::CH_U);
                        repeat ($urandom_range(0, 3))
                            queue_char(8'h30 + 8'($urandom_range(0, 9)));
                        do
                            c = 8'($urandom_range(0, 255));
                        while (hex_nibble(c) >= 0);
                        queue_char(c);
                    end
                    2:
                    begin
                        queue_end();
                    end
                    default:
                    begin
                        queue_char(8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
        total_items = source_todo.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (in_count < total_items)
            @(posedge clk);
        while (decoded_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && decoded_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
